// File: rtl/core/vpdt_pkg.sv
// Package for the vertex position dedup table.
// Holds payload structs, kind and status codes, controller types and the float compare.
// No dependencies.
package vpdt_pkg;

	localparam int TABLE_DEPTH_DEF = 256;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_LOOKUP = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	localparam logic [2:0] ST_MATCHED   = 3'd0;
	localparam logic [2:0] ST_INSERTED  = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_CLEARED   = 3'd4;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
	} vpdt_in_t;

	typedef struct packed {
		logic [7:0] unique_index;
		logic [2:0] status;
		logic [8:0] entry_count;
	} vpdt_out_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESULT
	} vpdt_state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} vpdt_cmd_t;

	typedef struct packed {
		logic is_clear;
		logic hit;
		logic scan_done;
		logic out_free;
	} vpdt_sts_t;

	function automatic logic is_nan32(input logic [31:0] v);
		return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
	endfunction

	// Numeric equality: NaN matches nothing, and both signed zeros are equal.
	function automatic logic num_equal(input logic [31:0] a, input logic [31:0] b);
		logic both_zero;
		both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
		return !is_nan32(a) && !is_nan32(b) && ((a == b) || both_zero);
	endfunction

endpackage

// File: rtl/core/vpdt_ctrl.sv
// Controller state machine for the vertex position dedup table.
// Sequences accept, table scan and result commit; depends on vpdt_pkg.
module vpdt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  vpdt_pkg::vpdt_sts_t sts,
	output vpdt_pkg::vpdt_cmd_t cmd
);
	import vpdt_pkg::*;

	vpdt_state_t state_q;
	vpdt_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		in_stall   = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.is_clear ? S_RESULT : S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit || sts.scan_done) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/core/vpdt_datapath.sv
// Datapath for the vertex position dedup table: item register, position memory,
// entry count, pipelined compare and output register; depends on vpdt_pkg.
module vpdt_datapath #(
	parameter int TABLE_DEPTH = vpdt_pkg::TABLE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vpdt_pkg::vpdt_in_t  in_data,
	input  vpdt_pkg::vpdt_cmd_t cmd,
	output vpdt_pkg::vpdt_sts_t sts,
	output logic                out_valid,
	input  logic                out_stall,
	output vpdt_pkg::vpdt_out_t out_data
);
	import vpdt_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	logic [95:0]      mem [TABLE_DEPTH];
	logic [95:0]      rd_data_s1;
	logic [CNT_W-1:0] rd_addr_s1;
	logic             rd_valid_s1;

	vpdt_in_t         item_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] addr_q;
	logic             found_q;
	logic [CNT_W-1:0] found_idx_q;
	logic             out_valid_q;
	vpdt_out_t        out_q;

	logic             rd_en;
	logic             wr_en;
	logic             equal;
	logic [CNT_W-1:0] res_index;
	logic [2:0]       res_status;
	logic [CNT_W-1:0] res_count;
	logic [CNT_W+7:0] index_wide;
	logic [CNT_W+8:0] count_wide;

	assign rd_en = cmd.scan && (addr_q < count_q);

	assign equal = num_equal(rd_data_s1[95:64], item_q.pos_x)
		&& num_equal(rd_data_s1[63:32], item_q.pos_y)
		&& num_equal(rd_data_s1[31:0], item_q.pos_z);

	assign sts.is_clear  = (in_data.kind == KIND_CLEAR);
	assign sts.hit       = rd_valid_s1 && equal;
	assign sts.scan_done = !rd_valid_s1 && (addr_q >= count_q);
	assign sts.out_free  = !out_valid_q || !out_stall;

	// Result selection for the item held in item_q.
	always_comb begin
		wr_en      = 1'b0;
		res_index  = '0;
		res_count  = count_q;
		res_status = ST_NOT_FOUND;
		if (item_q.kind == KIND_CLEAR) begin
			res_status = ST_CLEARED;
			res_count  = '0;
		end else if (found_q) begin
			res_status = ST_MATCHED;
			res_index  = found_idx_q;
		end else if (item_q.kind != KIND_INSERT) begin
			res_status = ST_NOT_FOUND;
		end else if (count_q >= DEPTH_C) begin
			res_status = ST_FULL;
		end else begin
			res_status = ST_INSERTED;
			res_index  = count_q;
			res_count  = count_q + 1'b1;
			wr_en      = cmd.commit;
		end
	end

	assign index_wide = {8'd0, res_index};
	assign count_wide = {9'd0, res_count};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[IDX_W-1:0]] <= {item_q.pos_x, item_q.pos_y, item_q.pos_z};
		end
		if (rd_en) begin
			rd_data_s1 <= mem[addr_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
		if (rd_en) begin
			rd_addr_s1 <= addr_q;
		end
		if (cmd.scan && sts.hit) begin
			found_idx_q <= rd_addr_s1;
		end
		if (cmd.commit) begin
			out_q.unique_index <= index_wide[7:0];
			out_q.status       <= res_status;
			out_q.entry_count  <= count_wide[8:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			addr_q      <= '0;
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				addr_q      <= '0;
				rd_valid_s1 <= 1'b0;
				found_q     <= 1'b0;
			end else if (cmd.scan) begin
				rd_valid_s1 <= rd_en;
				if (rd_en) begin
					addr_q <= addr_q + 1'b1;
				end
				if (sts.hit) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				count_q     <= res_count;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: rtl/core/vertex_position_dedup_table.sv
// Top level of the vertex position dedup table.
// Joins vpdt_ctrl and vpdt_datapath; depends on vpdt_pkg.
//
// Usage: an input transaction carries a kind and an x, y, z position as IEEE
// single bit patterns. Insert searches the table from entry zero and returns
// the first numerically equal entry, or appends the position, or reports the
// table full. Lookup only searches. Clear empties the table. Every input
// transaction yields exactly one output transaction with the index, a status
// and the entry count after the item.
// Timing: one item is in work at a time. With n entries held, an insert or
// lookup reads up to n entries between acceptance and the result register,
// fewer on an early match; a clear skips the scan. The next item is accepted
// at the earliest in the idle state after the result is registered, so a new
// item is never taken before the last one is committed. The scan reads one
// entry per cycle from the position memory, so the entry count sets the scan
// length, up to TABLE_DEPTH entries.
// Reset empties the table at once through the entry counter; the memory is not
// swept. in_stall is low only while the block is idle. The next item may be
// accepted while a result still waits; when out_stall holds the result, the
// following result waits inside the block until the output register is free.
module vertex_position_dedup_table #(
	parameter int TABLE_DEPTH = vpdt_pkg::TABLE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  vpdt_pkg::vpdt_in_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output vpdt_pkg::vpdt_out_t out_data
);
	import vpdt_pkg::*;

	vpdt_cmd_t cmd;
	vpdt_sts_t sts;

	vpdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	vpdt_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
